>>> design/isfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfd_pkg
// Shared types and constants for the IMU serial frame decoder.
// ----------------------------------------------------------------------------
package isfd_pkg;

  localparam logic [7:0] HeaderByte = 8'h55;
  localparam logic [7:0] TypeAccel  = 8'h51;
  localparam logic [7:0] TypeRate   = 8'h52;
  localparam logic [7:0] TypeAngle  = 8'h53;

  // Byte positions: 0 is the header, 1..9 are stored, 10 is the checksum.
  localparam int unsigned StoreDepth = 9;
  localparam logic [3:0]  LastIndex  = 4'd10;

  localparam logic signed [16:0] TempOffsetQ8 = 17'sd9280;

  typedef enum logic [1:0] {
    KindAccel = 2'd0,
    KindRate  = 2'd1,
    KindAngle = 2'd2
  } kind_e;

  // Completed frame handed from the framer to the scaler.
  typedef struct packed {
    logic                 done;
    logic [7:0]           kind_byte;
    logic [3:0][15:0]     words;      // X, Y, Z, temperature
  } frame_t;

endpackage

>>> design/isfd_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfd_framer
// Header hunt, byte position counter and store for frame bytes 1..9.
// ----------------------------------------------------------------------------
module isfd_framer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic [7:0]           byte_i,
  output isfd_pkg::frame_t     frame_o
);
  import isfd_pkg::*;

  logic [3:0] idx_q, idx_d;
  logic [7:0] store_q [StoreDepth];

  // Advance the position; drop non-header bytes while hunting.
  always_comb begin
    idx_d = idx_q;
    if (adv_i) begin
      if (idx_q == 4'd0) begin
        if (byte_i == HeaderByte) begin
          idx_d = 4'd1;
        end
      end else if (idx_q < LastIndex) begin
        idx_d = idx_q + 4'd1;
      end else begin
        idx_d = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  for (genvar i = 0; i < StoreDepth; i++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (adv_i && idx_q == 4'(i + 1)) begin
        store_q[i] <= byte_i;
      end
    end
  end

  // Checksum byte ends the frame; the store already holds the payload.
  always_comb begin
    frame_o.done      = adv_i && (idx_q >= LastIndex);
    frame_o.kind_byte = store_q[0];
    for (int w = 0; w < 4; w++) begin
      frame_o.words[w] = {store_q[2 * w + 2], store_q[2 * w + 1]};
    end
  end

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIndex)
    else $error("frame position out of range");

  a_done_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.done |=> (idx_q == 4'd0))
    else $error("framer did not return to header hunt");

  a_hunt_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && idx_q == 4'd0 && byte_i != HeaderByte) |=> (idx_q == 4'd0))
    else $error("non-header byte started a frame");

endmodule

>>> design/isfd_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isfd_scaler
// Type decode and constant scaling of the four frame words to Q8.
// ----------------------------------------------------------------------------
module isfd_scaler (
  input  isfd_pkg::frame_t     frame_i,
  output logic                 valid_o,
  output isfd_pkg::kind_e      kind_o,
  output logic signed [19:0]   x_o,
  output logic signed [19:0]   y_o,
  output logic signed [19:0]   z_o,
  output logic signed [16:0]   temp_o
);
  import isfd_pkg::*;

  logic signed [19:0] axis [3];
  logic signed [25:0] temp_prod;

  always_comb begin
    valid_o = 1'b1;
    kind_o  = KindAccel;
    case (frame_i.kind_byte)
      TypeAccel: kind_o = KindAccel;
      TypeRate:  kind_o = KindRate;
      TypeAngle: kind_o = KindAngle;
      default:   valid_o = 1'b0;
    endcase
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [15:0] raw;
    logic signed [22:0] prod_rate;
    logic signed [21:0] prod_angle;
    logic signed [22:0] raw_w23;
    logic signed [21:0] raw_w22;
    assign raw        = $signed(frame_i.words[a]);
    assign raw_w23    = 23'(raw);
    assign raw_w22    = 22'(raw);
    assign prod_rate  = raw_w23 * 23'sd125;
    assign prod_angle = raw_w22 * 22'sd45;
    always_comb begin
      case (kind_o)
        KindAccel: axis[a] = {{7{raw[15]}}, raw[15:3]};
        KindRate:  axis[a] = prod_rate[22:3];
        KindAngle: axis[a] = {{3{prod_angle[21]}}, prod_angle[21:5]};
        default:   axis[a] = '0;
      endcase
    end
  end

  assign temp_prod = 26'($signed(frame_i.words[3])) * 26'sd771;
  assign temp_o    = $signed({temp_prod[25], temp_prod[25:10]}) + TempOffsetQ8;

  assign x_o = axis[0];
  assign y_o = axis[1];
  assign z_o = axis[2];

endmodule

>>> design/imu_serial_frame_decoder_top.sv
`timescale 1ns / 1ps
// A frame's result enters the result register when its checksum byte leaves the
// input register, which it does only while the result register is free or draining.
// Throughput: one byte per cycle; an input register feeds the framer and
// scaler, and a result register holds the decoded frame for the consumer.
// The input stalls only while a byte waits, the result register is full and
// out_ready_i is low.
// Reset (rst_ni low, asynchronous): both stages empty, framer hunts for 0x55.
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder_top
// Decodes 11-byte IMU serial frames into Q8 acceleration, rate or angle
// values plus temperature.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           frame_kind_o,
  output logic signed [19:0]   x_value_o,
  output logic signed [19:0]   y_value_o,
  output logic signed [19:0]   z_value_o,
  output logic signed [16:0]   temperature_q8_o
);
  import isfd_pkg::*;

  // Input register stage.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       adv;

  // Result register stage.
  logic               out_valid_q, out_valid_d;
  kind_e              kind_q;
  logic signed [19:0] x_q, y_q, z_q;
  logic signed [16:0] temp_q;

  frame_t             frame;
  logic               dec_valid;
  kind_e              dec_kind;
  logic signed [19:0] dec_x, dec_y, dec_z;
  logic signed [16:0] dec_temp;
  logic               load;

  // Advance the held byte whenever the result slot is free or draining;
  // every byte waits on the same condition, whether or not it ends a frame.
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  isfd_framer u_framer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .byte_i  (in_byte_q),
    .frame_o (frame)
  );

  isfd_scaler u_scaler (
    .frame_i (frame),
    .valid_o (dec_valid),
    .kind_o  (dec_kind),
    .x_o     (dec_x),
    .y_o     (dec_y),
    .z_o     (dec_z),
    .temp_o  (dec_temp)
  );

  // Load a result only for a finished frame of a known type.
  assign load = frame.done && dec_valid;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= dec_kind;
      x_q    <= dec_x;
      y_q    <= dec_y;
      z_q    <= dec_z;
      temp_q <= dec_temp;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_kind_o     = kind_q;
  assign x_value_o        = x_q;
  assign y_value_o        = y_q;
  assign z_value_o        = z_q;
  assign temperature_q8_o = temp_q;

  a_load_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_result_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !load) |=> !out_valid_q)
    else $error("result repeated after transfer");

endmodule
